>>> hw/rtl/utf16_to_utf8_encoder_macros.svh
// Assertion macros used by the encoder's checker file.
`ifndef UTF16_TO_UTF8_ENCODER_MACROS_SVH
`define UTF16_TO_UTF8_ENCODER_MACROS_SVH

// Check a consequence in the same cycle as its cause.
`define U16U8_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its cause.
`define U16U8_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/u16u8_pkg.sv
// Types, constants and encoding functions shared by the UTF-16 to UTF-8 encoder.
package u16u8_pkg;

    localparam int UNIT_W    = 16;
    localparam int COUNT_W   = 16;
    localparam int CHAR_W    = 21;
    localparam int MAX_BEATS = 6;
    localparam int BEAT_W    = 3;
    localparam int TDATA_W   = 24;

    localparam logic [UNIT_W-1:0]  CAP_RESET  = 16'd512;
    localparam logic [UNIT_W-1:0]  HIGH_FIRST = 16'hD800;
    localparam logic [UNIT_W-1:0]  HIGH_LAST  = 16'hDBFF;
    localparam logic [UNIT_W-1:0]  LOW_FIRST  = 16'hDC00;
    localparam logic [UNIT_W-1:0]  LOW_LAST   = 16'hDFFF;
    localparam logic [CHAR_W-1:0]  LIMIT_1B   = 21'h00080;
    localparam logic [CHAR_W-1:0]  LIMIT_2B   = 21'h00800;
    localparam logic [CHAR_W-1:0]  LIMIT_3B   = 21'h10000;
    localparam logic [CHAR_W-1:0]  SUPP_BASE  = 21'h10000;
    localparam logic [7:0]         LEAD_2B    = 8'hC0;
    localparam logic [7:0]         LEAD_3B    = 8'hE0;
    localparam logic [7:0]         LEAD_4B    = 8'hF0;
    localparam logic [7:0]         CONT_MARK  = 8'h80;

    typedef logic [7:0] octet_t;

    typedef struct packed {
        octet_t [3:0] bytes;
        logic [2:0]   len;
    } utf8_seq_t;

    typedef struct packed {
        octet_t [MAX_BEATS-1:0] bytes;
        logic [BEAT_W-1:0]      cnt;
        logic                   term;
        logic [COUNT_W-1:0]     total;
    } burst_t;

    function automatic utf8_seq_t utf8_encode(input logic [CHAR_W-1:0] c);
        utf8_seq_t s;
        s.bytes = '0;
        if (c < LIMIT_1B)
        begin
            s.len      = 3'd1;
            s.bytes[0] = c[7:0];
        end
        else if (c < LIMIT_2B)
        begin
            s.len      = 3'd2;
            s.bytes[0] = LEAD_2B | {3'b000, c[10:6]};
            s.bytes[1] = CONT_MARK | {2'b00, c[5:0]};
        end
        else if (c < LIMIT_3B)
        begin
            s.len      = 3'd3;
            s.bytes[0] = LEAD_3B | {4'b0000, c[15:12]};
            s.bytes[1] = CONT_MARK | {2'b00, c[11:6]};
            s.bytes[2] = CONT_MARK | {2'b00, c[5:0]};
        end
        else
        begin
            s.len      = 3'd4;
            s.bytes[0] = LEAD_4B | {5'b00000, c[20:18]};
            s.bytes[1] = CONT_MARK | {2'b00, c[17:12]};
            s.bytes[2] = CONT_MARK | {2'b00, c[11:6]};
            s.bytes[3] = CONT_MARK | {2'b00, c[5:0]};
        end
        return s;
    endfunction

    function automatic logic fits(input logic [COUNT_W-1:0] used,
                                  input logic [2:0]         len,
                                  input logic [COUNT_W-1:0] cap);
        return ({1'b0, used} + {{(COUNT_W-2){1'b0}}, len}) < {1'b0, cap};
    endfunction

endpackage

>>> hw/rtl/u16u8_step.sv
// Input register, string state and per-unit encoding into a burst of up to six bytes.
module u16u8_step
    import u16u8_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [UNIT_W-1:0]  cfg_wdata,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [UNIT_W-1:0]  s_tdata,
    output logic               burst_valid,
    output burst_t             burst,
    input  logic               burst_ready
);

    logic               in_v_reg;
    logic [UNIT_W-1:0]  in_unit_reg;
    logic [UNIT_W-1:0]  cap_reg;
    logic [9:0]         held_hi_reg, held_hi_next;
    logic               held_v_reg, held_v_next;
    logic [COUNT_W-1:0] emitted_reg, emitted_next;
    logic               trunc_reg, trunc_next;

    logic               is_low, is_high, unit_zero, is_pair;
    logic [CHAR_W-1:0]  char_a, char_b;
    utf8_seq_t          seq_a, seq_b;
    logic               emit_a, emit_b, emit_term;
    logic [2:0]         len_a, len_b;
    logic [COUNT_W-1:0] total_sum;
    logic               advance;

    assign is_low    = (in_unit_reg >= LOW_FIRST) && (in_unit_reg <= LOW_LAST);
    assign is_high   = (in_unit_reg >= HIGH_FIRST) && (in_unit_reg <= HIGH_LAST);
    assign unit_zero = (in_unit_reg == '0);
    assign is_pair   = held_v_reg && is_low;

    assign char_a = is_pair ? (SUPP_BASE + {1'b0, held_hi_reg, in_unit_reg[9:0]})
                            : {5'b00000, HIGH_FIRST[15:10], held_hi_reg};
    assign char_b = {5'b00000, in_unit_reg};
    assign seq_a  = utf8_encode(char_a);
    assign seq_b  = utf8_encode(char_b);

    always_comb
    begin
        held_v_next  = held_v_reg;
        held_hi_next = held_hi_reg;
        emitted_next = emitted_reg;
        trunc_next   = trunc_reg;
        emit_a       = 1'b0;
        emit_b       = 1'b0;
        emit_term    = 1'b0;
        if (!trunc_reg)
        begin
            if (is_pair)
            begin
                held_v_next = 1'b0;
                if (fits(emitted_reg, seq_a.len, cap_reg))
                begin
                    emit_a       = 1'b1;
                    emitted_next = emitted_reg + {{(COUNT_W-3){1'b0}}, seq_a.len};
                end
                else
                begin
                    trunc_next = 1'b1;
                end
            end
            else
            begin
                if (held_v_reg)
                begin
                    held_v_next = 1'b0;
                    if (fits(emitted_reg, seq_a.len, cap_reg))
                    begin
                        emit_a       = 1'b1;
                        emitted_next = emitted_reg + {{(COUNT_W-3){1'b0}}, seq_a.len};
                    end
                    else
                    begin
                        trunc_next = 1'b1;
                    end
                end
                if (!trunc_next && !unit_zero)
                begin
                    if (is_high)
                    begin
                        held_hi_next = in_unit_reg[9:0];
                        held_v_next  = 1'b1;
                    end
                    else if (fits(emitted_next, seq_b.len, cap_reg))
                    begin
                        emit_b       = 1'b1;
                        emitted_next = emitted_next + {{(COUNT_W-3){1'b0}}, seq_b.len};
                    end
                    else
                    begin
                        trunc_next  = 1'b1;
                        held_v_next = 1'b0;
                    end
                end
            end
        end
        total_sum = emitted_next + {{(COUNT_W-1){1'b0}}, 1'b1};
        if (unit_zero)
        begin
            emit_term    = (cap_reg != '0);
            held_hi_next = '0;
            held_v_next  = 1'b0;
            emitted_next = '0;
            trunc_next   = 1'b0;
        end
    end

    assign len_a = emit_a ? seq_a.len : 3'd0;
    assign len_b = emit_b ? seq_b.len : 3'd0;

    always_comb
    begin : assemble
        logic [2:0] slot;
        logic [2:0] rel;
        for (int i = 0; i < MAX_BEATS; i++)
        begin
            slot = 3'(i);
            rel  = slot - len_a;
            if (slot < len_a)
            begin
                burst.bytes[i] = seq_a.bytes[slot[1:0]];
            end
            else if (rel < len_b)
            begin
                burst.bytes[i] = seq_b.bytes[rel[1:0]];
            end
            else
            begin
                burst.bytes[i] = '0;
            end
        end
        burst.cnt   = len_a + len_b + {2'b00, emit_term};
        burst.term  = emit_term;
        burst.total = total_sum;
    end

    assign burst_valid = in_v_reg;
    assign advance     = in_v_reg && burst_ready;
    assign s_tready    = !in_v_reg || burst_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg    <= 1'b0;
            cap_reg     <= CAP_RESET;
            held_hi_reg <= '0;
            held_v_reg  <= 1'b0;
            emitted_reg <= '0;
            trunc_reg   <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_v_reg <= s_tvalid;
            end
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
            if (advance)
            begin
                held_hi_reg <= held_hi_next;
                held_v_reg  <= held_v_next;
                emitted_reg <= emitted_next;
                trunc_reg   <= trunc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_unit_reg <= s_tdata;
        end
    end

endmodule

>>> hw/rtl/u16u8_emit.sv
// Result register that holds one burst and sends its bytes one beat at a time.
module u16u8_emit
    import u16u8_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               burst_valid,
    input  burst_t             burst,
    output logic               burst_ready,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,
    output logic               m_tlast,
    output logic               m_tuser
);

    logic              buf_v_reg;
    burst_t            buf_reg;
    logic [BEAT_W-1:0] idx_reg;
    logic              last_beat;
    logic              done;
    logic              load;
    logic              eos;

    assign last_beat   = (idx_reg == BEAT_W'(buf_reg.cnt - 3'd1));
    assign done        = buf_v_reg && m_tready && last_beat;
    assign burst_ready = !buf_v_reg || done;
    assign load        = burst_valid && burst_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_v_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            if (load)
            begin
                buf_v_reg <= (burst.cnt != '0);
                idx_reg   <= '0;
            end
            else if (done)
            begin
                buf_v_reg <= 1'b0;
            end
            else if (buf_v_reg && m_tready)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            buf_reg <= burst;
        end
    end

    assign eos      = buf_reg.term && last_beat;
    assign m_tvalid = buf_v_reg;
    assign m_tlast  = last_beat;
    assign m_tuser  = eos;
    assign m_tdata  = {(eos ? buf_reg.total : {COUNT_W{1'b0}}), buf_reg.bytes[idx_reg]};

endmodule

>>> hw/rtl/utf16_to_utf8_encoder.sv
// UTF-16 to UTF-8 encoder top level.
// Takes one UTF-16 code unit per beat and sends UTF-8 one byte per beat. A unit can be
// taken every cycle while the byte output does not hold it back; the byte output sets the
// pace. Most units cause 1 to 3 bytes, a surrogate pair 4, and up to 6 are caused
// when a held high surrogate is flushed ahead of a following unit; none are caused by a
// held high surrogate or a unit after truncation. The first byte passes the input register
// and then the result register before it is presented. The terminator byte carries the
// string length in total_bytes and marks end_of_string.
module utf16_to_utf8_encoder
    import u16u8_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [UNIT_W-1:0]  cfg_wdata,   // capacity
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [UNIT_W-1:0]  s_tdata,     // [15:0] code_unit
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,     // [7:0] out_byte, [23:8] total_bytes
    output logic               m_tlast,     // last_of_item
    output logic               m_tuser      // end_of_string
);

    logic   burst_valid;
    logic   burst_ready;
    burst_t burst;

    u16u8_step u_step (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .burst_valid (burst_valid),
        .burst       (burst),
        .burst_ready (burst_ready)
    );

    u16u8_emit u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .burst_valid (burst_valid),
        .burst       (burst),
        .burst_ready (burst_ready),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

endmodule

>>> hw/rtl/u16u8_checker.sv
// Port-level assertions for the encoder, bound to its top level.
`include "utf16_to_utf8_encoder_macros.svh"

module u16u8_checker
    import u16u8_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [TDATA_W-1:0] m_tdata,
    input logic               m_tlast,
    input logic               m_tuser
);

    `U16U8_ASSERT_SAME(a_eos_is_last, m_tvalid && m_tuser, m_tlast, "terminator not last of unit")
    `U16U8_ASSERT_SAME(a_eos_zero_byte, m_tvalid && m_tuser, m_tdata[7:0] == 8'h00, "terminator byte not zero")
    `U16U8_ASSERT_SAME(a_total_only_eos, m_tvalid && !m_tuser, m_tdata[23:8] == 16'h0000, "total_bytes set off terminator")
    `U16U8_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser), "stalled beat changed")

endmodule

bind utf16_to_utf8_encoder u16u8_checker u_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

>>> bench/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for the UTF-16 to UTF-8 encoder: directed table plus random strings.
module tb;
    import u16u8_pkg::*;

    localparam int RANDOM_UNITS = 140;
    localparam int SETTLE_CYCLES = 12;
    localparam int CYCLE_LIMIT = 400000;

    typedef enum logic {ROW_UNIT, ROW_CAP} row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [15:0] val;
        logic        typed;
        logic [2:0]  nexp;
        logic [31:0] seq;
        logic [15:0] total;
    } dir_row_t;

    typedef struct {
        logic [7:0]  octet;
        logic        last;
        logic        eos;
        logic [15:0] total;
    } utf8_beat_t;

    localparam int DIR_ROWS = 31;

    dir_row_t dir_rows [DIR_ROWS] = '{
        '{ROW_UNIT, 16'h0000, 1'b1, 3'd1, 32'h00000000, 16'd1},
        '{ROW_UNIT, 16'h0041, 1'b1, 3'd1, 32'h00000041, 16'd0},
        '{ROW_UNIT, 16'h0080, 1'b1, 3'd2, 32'h000080C2, 16'd0},
        '{ROW_UNIT, 16'h07FF, 1'b1, 3'd2, 32'h0000BFDF, 16'd0},
        '{ROW_UNIT, 16'h0800, 1'b1, 3'd3, 32'h0080A0E0, 16'd0},
        '{ROW_UNIT, 16'hFFFF, 1'b1, 3'd3, 32'h00BFBFEF, 16'd0},
        '{ROW_UNIT, 16'hD83D, 1'b1, 3'd0, 32'h00000000, 16'd0},
        '{ROW_UNIT, 16'hDE00, 1'b0, 3'd0, 32'h00000000, 16'd0},
        '{ROW_UNIT, 16'hDBFF, 1'b1, 3'd0, 32'h00000000, 16'd0},
        '{ROW_UNIT, 16'hDFFF, 1'b1, 3'd4, 32'hBFBF8FF4, 16'd0},
        '{ROW_UNIT, 16'hD800, 1'b1, 3'd0, 32'h00000000, 16'd0},
        '{ROW_UNIT, 16'h0042, 1'b0, 3'd0, 32'h00000000, 16'd0},
        '{ROW_UNIT, 16'hDC00, 1'b0, 3'd0, 32'h00000000, 16'd0},
        '{ROW_UNIT, 16'hDBFF, 1'b1, 3'd0, 32'h00000000, 16'd0},
        '{ROW_UNIT, 16'h0000, 1'b0, 3'd0, 32'h00000000, 16'd0},
        '{ROW_CAP,  16'd0,    1'b0, 3'd0, 32'h00000000, 16'd0},
        '{ROW_UNIT, 16'h0041, 1'b1, 3'd0, 32'h00000000, 16'd0},
        '{ROW_UNIT, 16'h0000, 1'b1, 3'd0, 32'h00000000, 16'd0},
        '{ROW_CAP,  16'd4,    1'b0, 3'd0, 32'h00000000, 16'd0},
        '{ROW_UNIT, 16'h0041, 1'b1, 3'd1, 32'h00000041, 16'd0},
        '{ROW_UNIT, 16'hD800, 1'b1, 3'd0, 32'h00000000, 16'd0},
        '{ROW_UNIT, 16'h0800, 1'b1, 3'd0, 32'h00000000, 16'd0},
        '{ROW_UNIT, 16'h0000, 1'b1, 3'd1, 32'h00000000, 16'd2},
        '{ROW_UNIT, 16'hD800, 1'b1, 3'd0, 32'h00000000, 16'd0},
        '{ROW_UNIT, 16'hDC00, 1'b1, 3'd0, 32'h00000000, 16'd0},
        '{ROW_UNIT, 16'h0000, 1'b1, 3'd1, 32'h00000000, 16'd1},
        '{ROW_UNIT, 16'h007F, 1'b1, 3'd1, 32'h0000007F, 16'd0},
        '{ROW_CAP,  16'd2,    1'b0, 3'd0, 32'h00000000, 16'd0},
        '{ROW_UNIT, 16'h0042, 1'b1, 3'd0, 32'h00000000, 16'd0},
        '{ROW_UNIT, 16'h0000, 1'b1, 3'd1, 32'h00000000, 16'd2},
        '{ROW_CAP,  16'hFFFF, 1'b0, 3'd0, 32'h00000000, 16'd0}
    };

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [UNIT_W-1:0]  cfg_wdata = '0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [UNIT_W-1:0]  s_tdata = '0;     // [15:0] code_unit
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;          // [7:0] out_byte, [23:8] total_bytes
    logic               m_tlast;          // last_of_item
    logic               m_tuser;          // end_of_string

    logic [15:0] cap_reg = CAP_RESET;
    logic [9:0]  held_bits = '0;
    logic        held_ok = 1'b0;
    logic [15:0] used_cnt = '0;
    logic        cut_flag = 1'b0;

    utf8_beat_t fresh_q [$];
    utf8_beat_t utf8_expect_q [$];
    int         err_cnt = 0;
    int         cycle_cnt = 0;
    bit         tx_calm = 1'b0;

    utf16_to_utf8_encoder u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
    end

    task automatic put_octet(input logic [7:0] b);
        fresh_q.push_back('{b, 1'b0, 1'b0, 16'd0});
    endtask

    task automatic encode_char(input logic [20:0] c);
        int n;
        n = (c < 21'h80) ? 1 : (c < 21'h800) ? 2 : (c < 21'h10000) ? 3 : 4;
        if (int'(used_cnt) + n >= int'(cap_reg))
        begin
            cut_flag = 1'b1;
            held_ok = 1'b0;
        end
        else
        begin
            case (n)
                1: put_octet(c[7:0]);
                2:
                begin
                    put_octet({3'b110, c[10:6]});
                    put_octet({2'b10, c[5:0]});
                end
                3:
                begin
                    put_octet({4'b1110, c[15:12]});
                    put_octet({2'b10, c[11:6]});
                    put_octet({2'b10, c[5:0]});
                end
                default:
                begin
                    put_octet({5'b11110, c[20:18]});
                    put_octet({2'b10, c[17:12]});
                    put_octet({2'b10, c[11:6]});
                    put_octet({2'b10, c[5:0]});
                end
            endcase
            used_cnt = used_cnt + 16'(n);
        end
    endtask

    task automatic predict_unit(input logic [15:0] u);
        logic is_lo;
        logic is_hi;
        bit   paired;
        is_lo = (u >= LOW_FIRST) && (u <= LOW_LAST);
        is_hi = (u >= HIGH_FIRST) && (u <= HIGH_LAST);
        paired = 1'b0;
        fresh_q.delete();
        if (!cut_flag)
        begin
            if (held_ok && is_lo)
            begin
                held_ok = 1'b0;
                paired = 1'b1;
                encode_char(21'h10000 + (21'(held_bits) << 10) + 21'(u[9:0]));
            end
            else
            begin
                if (held_ok)
                begin
                    held_ok = 1'b0;
                    encode_char(21'(HIGH_FIRST | 16'(held_bits)));
                end
                if (!cut_flag && u != 16'h0000)
                begin
                    if (is_hi)
                    begin
                        held_bits = u[9:0];
                        held_ok = 1'b1;
                    end
                    else
                        encode_char(21'(u));
                end
            end
        end
        if (!paired && u == 16'h0000)
        begin
            if (cap_reg != 16'd0)
                fresh_q.push_back('{8'h00, 1'b0, 1'b1, used_cnt + 16'd1});
            held_bits = '0;
            held_ok = 1'b0;
            used_cnt = '0;
            cut_flag = 1'b0;
        end
        if (fresh_q.size() > 0)
            fresh_q[fresh_q.size() - 1].last = 1'b1;
    endtask

    task automatic send_unit(input logic [15:0] u, input bit keep);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 4);
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            s_tdata = 16'($urandom);
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata = u;
        do @(posedge clk); while (!s_tready);
        predict_unit(u);
        if (keep)
            foreach (fresh_q[j])
                utf8_expect_q.push_back(fresh_q[j]);
    endtask

    task automatic write_capacity(input logic [15:0] v);
        @(negedge clk);
        s_tvalid = 1'b0;
        while (utf8_expect_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_wdata = v;
        @(negedge clk);
        cfg_we = 1'b0;
        cap_reg = v;
    endtask

    function automatic logic [15:0] pick_capacity();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: return 16'd0;
            1: return 16'd1;
            2: return 16'hFFFF;
            3: return CAP_RESET;
            4: return 16'($urandom_range(0, 65535));
            default: return 16'($urandom_range(2, 30));
        endcase
    endfunction

    function automatic logic [15:0] pick_bmp();
        int r;
        r = $urandom_range(0, 2);
        case (r)
            0: return 16'($urandom_range(1, 16'h007F));
            1: return 16'($urandom_range(16'h0080, 16'h07FF));
            default:
                return ($urandom_range(0, 1) == 0) ? 16'($urandom_range(16'h0800, 16'hD7FF))
                                                  : 16'($urandom_range(16'hE000, 16'hFFFF));
        endcase
    endfunction

    initial
    begin
        int         i;
        int         k;
        int         slen;
        int         pick;
        int         rnd_sent;
        bit         noisy;
        dir_row_t   row;
        utf8_beat_t beat;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (i = 0; i < DIR_ROWS; i++)
        begin
            row = dir_rows[i];
            tx_calm = (i % 8) < 3;
            if (row.kind == ROW_CAP)
                write_capacity(row.val);
            else
            begin
                send_unit(row.val, !row.typed);
                if (row.typed)
                    for (k = 0; k < int'(row.nexp); k++)
                    begin
                        beat.octet = row.seq[8*k +: 8];
                        beat.last = (k == int'(row.nexp) - 1);
                        beat.eos = beat.last && (row.val == 16'h0000);
                        beat.total = beat.eos ? row.total : 16'd0;
                        utf8_expect_q.push_back(beat);
                    end
            end
        end

        rnd_sent = 0;
        while (rnd_sent < RANDOM_UNITS)
        begin
            if ($urandom_range(0, 3) == 0)
                write_capacity(pick_capacity());
            tx_calm = ($urandom_range(0, 4) == 0);
            noisy = ($urandom_range(0, 9) == 0);
            slen = $urandom_range(0, 10);
            for (k = 0; k < slen; k++)
            begin
                if (!noisy && $urandom_range(0, 19) == 0)
                    write_capacity(pick_capacity());
                pick = $urandom_range(0, 99);
                if (noisy || pick >= 94)
                    send_unit(16'($urandom_range(0, 65535)), 1'b1);
                else if (pick < 55)
                    send_unit(pick_bmp(), 1'b1);
                else if (pick < 77)
                begin
                    send_unit(16'($urandom_range(HIGH_FIRST, HIGH_LAST)), 1'b1);
                    send_unit(16'($urandom_range(LOW_FIRST, LOW_LAST)), 1'b1);
                    rnd_sent++;
                end
                else if (pick < 87)
                    send_unit(16'($urandom_range(HIGH_FIRST, HIGH_LAST)), 1'b1);
                else
                    send_unit(16'($urandom_range(LOW_FIRST, LOW_LAST)), 1'b1);
                rnd_sent++;
            end
            send_unit(16'h0000, 1'b1);
            rnd_sent++;
        end

        @(negedge clk);
        s_tvalid = 1'b0;
        while (utf8_expect_q.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (err_cnt == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        int         stall;
        bit         rx_calm;
        utf8_beat_t want;
        rx_calm = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 15) == 0)
                rx_calm = !rx_calm;
            stall = rx_calm ? 0 : $urandom_range(0, 4);
            @(negedge clk);
            if (stall > 0)
            begin
                m_tready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready = 1'b1;
            do @(posedge clk); while (!m_tvalid);
            if (utf8_expect_q.size() == 0)
            begin
                $error("unexpected beat: out_byte %0h", m_tdata[7:0]);
                err_cnt++;
            end
            else
            begin
                want = utf8_expect_q.pop_front();
                if (m_tdata[7:0] !== want.octet)
                begin
                    $error("out_byte: expected %0h, got %0h", want.octet, m_tdata[7:0]);
                    err_cnt++;
                end
                if (m_tlast !== want.last)
                begin
                    $error("last_of_item: expected %0b, got %0b", want.last, m_tlast);
                    err_cnt++;
                end
                if (m_tuser !== want.eos)
                begin
                    $error("end_of_string: expected %0b, got %0b", want.eos, m_tuser);
                    err_cnt++;
                end
                if (m_tdata[23:8] !== want.total)
                begin
                    $error("total_bytes: expected %0d, got %0d", want.total, m_tdata[23:8]);
                    err_cnt++;
                end
            end
        end
    end

    initial
    begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/u16u8_pkg.sv
hw/rtl/u16u8_step.sv
hw/rtl/u16u8_emit.sv
hw/rtl/utf16_to_utf8_encoder.sv
hw/rtl/u16u8_checker.sv
bench/tb.sv
